// ----- rtl/core/tfn_pkg.sv -----
// shared constants for the triangle face normal core
// no dependencies

package tfn_pkg;

    localparam int COORD_BITS_DEF       = 24;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int INDEX_BITS_DEF       = 16;

    // the largest scaled magnitude lies in [2^30, 2^31)
    localparam int MAG_BITS  = 31;
    localparam int SUM_BITS  = 64;
    localparam int ROOT_BITS = 32;

endpackage

// ----- rtl/core/tfn_cross.sv -----
// edge vectors and exact cross product, three register stages
// depends on tfn_pkg

module tfn_cross import tfn_pkg::*; #(
    parameter int CB     = COORD_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [CB-1:0]  i_c [9],
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic signed [2*CB+2:0] o_cross [3],
    output logic [SIDE_W-1:0]     o_side
);

    localparam int EW = CB + 1;
    localparam int PW = 2 * CB + 2;
    localparam int XW = 2 * CB + 3;

    logic                 r_v1, r_v2, r_v3;
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [PW-1:0] r_p [6];
    logic signed [XW-1:0] r_x [3];
    logic [SIDE_W-1:0]    r_s1, r_s2, r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= EW'(i_c[3+k]) - EW'(i_c[k]);
                r_e2[k] <= EW'(i_c[6+k]) - EW'(i_c[k]);
            end
            r_s1 <= i_side;
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
            r_s2 <= r_s1;
            for (int k = 0; k < 3; k++) begin
                r_x[k] <= XW'(r_p[2*k]) - XW'(r_p[2*k+1]);
            end
            r_s3 <= r_s2;
        end
    end

    assign o_valid = r_v3;
    assign o_cross = r_x;
    assign o_side  = r_s3;

endmodule

// ----- rtl/core/tfn_scale.sv -----
// magnitude, common shift of the largest into [2^30, 2^31) and sum of squares, five stages
// depends on tfn_pkg

module tfn_scale import tfn_pkg::*; #(
    parameter int CB     = COORD_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [2*CB+2:0]  i_cross [3],
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic [MAG_BITS-1:0]     o_m [3],
    output logic [SUM_BITS-1:0]     o_sum,
    output logic [2:0]              o_neg,
    output logic                    o_degen,
    output logic [SIDE_W-1:0]       o_side
);

    localparam int MW = 2 * CB + 2;
    localparam int LW = $clog2(MW + 1);
    localparam int SW = (MW > MAG_BITS) ? MW : MAG_BITS;
    localparam int QW = 2 * MAG_BITS;

    logic                  r_va, r_vb, r_vc, r_vd, r_ve;
    logic [MW-1:0]         r_mag_a [3];
    logic [MW-1:0]         r_mag_b [3];
    logic [LW-1:0]         r_l;
    logic [MAG_BITS-1:0]   r_m_c [3];
    logic [MAG_BITS-1:0]   r_m_d [3];
    logic [MAG_BITS-1:0]   r_m_e [3];
    logic [QW-1:0]         r_sq [3];
    logic [SUM_BITS-1:0]   r_sum;
    logic [2:0]            r_neg_a, r_neg_b, r_neg_c, r_neg_d, r_neg_e;
    logic                  r_z_c, r_z_d, r_z_e;
    logic [SIDE_W-1:0]     r_sa, r_sb, r_sc, r_sd, r_se;

    logic [MW-1:0]         n_mag [3];
    logic [MW-1:0]         mag_or;
    logic [LW-1:0]         n_l;
    logic [MAG_BITS-1:0]   n_m [3];
    logic [SW-1:0]         shifted [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = i_cross[k][2*CB+2] ? MW'(-i_cross[k]) : MW'(i_cross[k]);
        end
    end

    // bit length of the largest magnitude
    always_comb begin
        mag_or = r_mag_a[0] | r_mag_a[1] | r_mag_a[2];
        n_l    = '0;
        for (int i = 0; i < MW; i++) begin
            if (mag_or[i]) begin
                n_l = LW'(i + 1);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_l > LW'(MAG_BITS)) begin
                shifted[k] = SW'(r_mag_b[k]) >> (r_l - LW'(MAG_BITS));
            end else begin
                shifted[k] = SW'(r_mag_b[k]) << (LW'(MAG_BITS) - r_l);
            end
            n_m[k] = shifted[k][MAG_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_mag_a[k] <= n_mag[k];
                r_neg_a[k] <= i_cross[k][2*CB+2];
            end
            r_sa <= i_side;

            r_mag_b <= r_mag_a;
            r_l     <= n_l;
            r_neg_b <= r_neg_a;
            r_sb    <= r_sa;

            r_m_c   <= n_m;
            r_z_c   <= (r_l == '0);
            r_neg_c <= r_neg_b;
            r_sc    <= r_sb;

            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= QW'(r_m_c[k]) * QW'(r_m_c[k]);
            end
            r_m_d   <= r_m_c;
            r_z_d   <= r_z_c;
            r_neg_d <= r_neg_c;
            r_sd    <= r_sc;

            r_sum   <= SUM_BITS'(r_sq[0]) + SUM_BITS'(r_sq[1]) + SUM_BITS'(r_sq[2]);
            r_m_e   <= r_m_d;
            r_z_e   <= r_z_d;
            r_neg_e <= r_neg_d;
            r_se    <= r_sd;
        end
    end

    assign o_valid = r_ve;
    assign o_m     = r_m_e;
    assign o_sum   = r_sum;
    assign o_neg   = r_neg_e;
    assign o_degen = r_z_e;
    assign o_side  = r_se;

endmodule

// ----- rtl/core/tfn_isqrt.sv -----
// pipelined integer square root, one result bit per stage
// depends on tfn_pkg

module tfn_isqrt import tfn_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [SUM_BITS-1:0]   i_val,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [ROOT_BITS-1:0]  o_root,
    output logic [SIDE_W-1:0]     o_side
);

    logic [SUM_BITS-1:0] r_rem [ROOT_BITS];
    logic [SUM_BITS-1:0] r_res [ROOT_BITS];
    logic [ROOT_BITS-1:0] r_vld;
    logic [SIDE_W-1:0]   r_sd [ROOT_BITS];

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_stage
        localparam logic [SUM_BITS-1:0] BIT = SUM_BITS'(1) << (2 * (ROOT_BITS - 1 - g));

        logic [SUM_BITS-1:0] rem_in, res_in, trial, rem_nx, res_nx;
        logic                vld_in;
        logic [SIDE_W-1:0]   sd_in;

        if (g == 0) begin : g_first
            assign rem_in = i_val;
            assign res_in = '0;
            assign vld_in = i_valid;
            assign sd_in  = i_side;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign res_in = r_res[g-1];
            assign vld_in = r_vld[g-1];
            assign sd_in  = r_sd[g-1];
        end

        always_comb begin
            trial = res_in + BIT;
            if (rem_in >= trial) begin
                rem_nx = rem_in - trial;
                res_nx = (res_in >> 1) + BIT;
            end else begin
                rem_nx = rem_in;
                res_nx = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= rem_nx;
                r_res[g] <= res_nx;
                r_sd[g]  <= sd_in;
            end
        end
    end

    assign o_valid = r_vld[ROOT_BITS-1];
    assign o_root  = r_res[ROOT_BITS-1][ROOT_BITS-1:0];
    assign o_side  = r_sd[ROOT_BITS-1];

endmodule

// ----- rtl/core/tfn_div.sv -----
// rounded division of three magnitudes by the length, restoring, one bit per stage
// depends on tfn_pkg

module tfn_div import tfn_pkg::*; #(
    parameter int F      = NORMAL_FRAC_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [MAG_BITS-1:0]   i_m [3],
    input  logic [ROOT_BITS-1:0]  i_len,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [F:0]            o_q [3],
    output logic [SIDE_W-1:0]     o_side
);

    localparam int NW = ROOT_BITS + F + 1;
    localparam int NS = F + 1;

    logic                 r_pv;
    logic [NW-1:0]        r_pn [3];
    logic [ROOT_BITS-1:0] r_plen;
    logic [SIDE_W-1:0]    r_ps;

    logic [NW-1:0]        r_rem [NS][3];
    logic [F:0]           r_q [NS][3];
    logic [ROOT_BITS-1:0] r_len [NS];
    logic [NS-1:0]        r_vld;
    logic [SIDE_W-1:0]    r_sd [NS];

    // numerator with half the divisor added for rounding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pn[k] <= (NW'(i_m[k]) << F) + NW'(i_len >> 1);
            end
            r_plen <= i_len;
            r_ps   <= i_side;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_stage
        localparam int K = F - g;

        logic [NW-1:0]        rem_in [3];
        logic [F:0]           q_in [3];
        logic [ROOT_BITS-1:0] len_in;
        logic                 vld_in;
        logic [SIDE_W-1:0]    sd_in;
        logic [NW-1:0]        dsh;
        logic [NW-1:0]        rem_nx [3];
        logic [F:0]           q_nx [3];

        if (g == 0) begin : g_first
            assign rem_in = r_pn;
            assign q_in   = '{default: '0};
            assign len_in = r_plen;
            assign vld_in = r_pv;
            assign sd_in  = r_ps;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign q_in   = r_q[g-1];
            assign len_in = r_len[g-1];
            assign vld_in = r_vld[g-1];
            assign sd_in  = r_sd[g-1];
        end

        always_comb begin
            dsh = NW'(len_in) << K;
            for (int k = 0; k < 3; k++) begin
                q_nx[k] = q_in[k];
                if (rem_in[k] >= dsh) begin
                    rem_nx[k]  = rem_in[k] - dsh;
                    q_nx[k][K] = 1'b1;
                end else begin
                    rem_nx[k] = rem_in[k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= rem_nx;
                r_q[g]   <= q_nx;
                r_len[g] <= len_in;
                r_sd[g]  <= sd_in;
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_q     = r_q[NS-1];
    assign o_side  = r_sd[NS-1];

endmodule

// ----- rtl/core/triangle_face_normal_core.sv -----
// triangle face normal core: top level
// depends on tfn_pkg, tfn_cross, tfn_scale, tfn_isqrt, tfn_div
//
// One triangle beat in, one normal beat out. The input beat carries three
// signed corners and three vertex indices; the output beat carries the unit
// normal in signed Q1.F, a degenerate flag and the three indices unchanged.
// A beat moves when valid is high and stall is low on that channel.
// A degenerate triangle (zero cross product) gives a zero normal with the
// flag set.
// The pipe runs edges and cross product, then the shift and sum of squares,
// then the square root pipe, which yields the root bit by bit, then the
// numerator register and the quotient bits in the dividers, and last the
// output register.
// Throughput is one beat per cycle while the output is not stalled. The whole pipe moves on one enable;
// while the output beat is held by i_stall, every stage holds and o_stall
// goes high, so nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; the pipe is empty
// and ready on the first cycle after reset.

module triangle_face_normal_core import tfn_pkg::*; #(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
    parameter int INDEX_BITS       = INDEX_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_BITS-1:0]  i_corner0_x,
    input  logic signed [COORD_BITS-1:0]  i_corner0_y,
    input  logic signed [COORD_BITS-1:0]  i_corner0_z,
    input  logic signed [COORD_BITS-1:0]  i_corner1_x,
    input  logic signed [COORD_BITS-1:0]  i_corner1_y,
    input  logic signed [COORD_BITS-1:0]  i_corner1_z,
    input  logic signed [COORD_BITS-1:0]  i_corner2_x,
    input  logic signed [COORD_BITS-1:0]  i_corner2_y,
    input  logic signed [COORD_BITS-1:0]  i_corner2_z,
    input  logic [INDEX_BITS-1:0]         i_corner0_index,
    input  logic [INDEX_BITS-1:0]         i_corner1_index,
    input  logic [INDEX_BITS-1:0]         i_corner2_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_z,
    output logic                          o_degenerate,
    output logic [INDEX_BITS-1:0]         o_out_index0,
    output logic [INDEX_BITS-1:0]         o_out_index1,
    output logic [INDEX_BITS-1:0]         o_out_index2
);

    localparam int F   = NORMAL_FRAC_BITS;
    localparam int NWD = F + 2;
    localparam int XW  = 2 * COORD_BITS + 3;
    localparam int IW  = 3 * INDEX_BITS;
    localparam int SQW = 3 + 1 + 3 * MAG_BITS + IW;
    localparam int DVW = 3 + 1 + IW;

    logic en;

    logic signed [COORD_BITS-1:0] corners [9];

    logic                   cr_valid;
    logic signed [XW-1:0]   cr_cross [3];
    logic [IW-1:0]          cr_side;

    logic                   sc_valid;
    logic [MAG_BITS-1:0]    sc_m [3];
    logic [SUM_BITS-1:0]    sc_sum;
    logic [2:0]             sc_neg;
    logic                   sc_degen;
    logic [IW-1:0]          sc_side;

    logic                   sq_valid;
    logic [ROOT_BITS-1:0]   sq_root;
    logic [SQW-1:0]         sq_side_in, sq_side;
    logic [MAG_BITS-1:0]    sq_m [3];
    logic [2:0]             sq_neg;
    logic                   sq_degen;
    logic [IW-1:0]          sq_idx;

    logic                   dv_valid;
    logic [F:0]             dv_q [3];
    logic [DVW-1:0]         dv_side;
    logic [2:0]             dv_neg;
    logic                   dv_degen;
    logic [IW-1:0]          dv_idx;

    logic                   r_valid;
    logic signed [NWD-1:0]  r_nx, r_ny, r_nz;
    logic                   r_degen;
    logic [IW-1:0]          r_idx;
    logic signed [NWD-1:0]  n_norm [3];

    assign en      = ~r_valid | ~i_stall;
    assign o_stall = ~en;

    assign corners = '{i_corner0_x, i_corner0_y, i_corner0_z,
                       i_corner1_x, i_corner1_y, i_corner1_z,
                       i_corner2_x, i_corner2_y, i_corner2_z};

    tfn_cross #(
        .CB     (COORD_BITS),
        .SIDE_W (IW)
    ) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_c     (corners),
        .i_side  ({i_corner2_index, i_corner1_index, i_corner0_index}),
        .o_valid (cr_valid),
        .o_cross (cr_cross),
        .o_side  (cr_side)
    );

    tfn_scale #(
        .CB     (COORD_BITS),
        .SIDE_W (IW)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cr_valid),
        .i_cross (cr_cross),
        .i_side  (cr_side),
        .o_valid (sc_valid),
        .o_m     (sc_m),
        .o_sum   (sc_sum),
        .o_neg   (sc_neg),
        .o_degen (sc_degen),
        .o_side  (sc_side)
    );

    assign sq_side_in = {sc_neg, sc_degen, sc_m[2], sc_m[1], sc_m[0], sc_side};

    tfn_isqrt #(
        .SIDE_W (SQW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sc_valid),
        .i_val   (sc_sum),
        .i_side  (sq_side_in),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign {sq_neg, sq_degen, sq_m[2], sq_m[1], sq_m[0], sq_idx} = sq_side;

    tfn_div #(
        .F      (F),
        .SIDE_W (DVW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_m     (sq_m),
        .i_len   (sq_root),
        .i_side  ({sq_neg, sq_degen, sq_idx}),
        .o_valid (dv_valid),
        .o_q     (dv_q),
        .o_side  (dv_side)
    );

    assign {dv_neg, dv_degen, dv_idx} = dv_side;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (dv_degen) begin
                n_norm[k] = '0;
            end else if (dv_neg[k]) begin
                n_norm[k] = -NWD'(dv_q[k]);
            end else begin
                n_norm[k] = NWD'(dv_q[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx    <= n_norm[0];
            r_ny    <= n_norm[1];
            r_nz    <= n_norm[2];
            r_degen <= dv_degen;
            r_idx   <= dv_idx;
        end
    end

    assign o_valid      = r_valid;
    assign o_normal_x   = r_nx;
    assign o_normal_y   = r_ny;
    assign o_normal_z   = r_nz;
    assign o_degenerate = r_degen;
    assign o_out_index0 = r_idx[INDEX_BITS-1:0];
    assign o_out_index1 = r_idx[2*INDEX_BITS-1:INDEX_BITS];
    assign o_out_index2 = r_idx[3*INDEX_BITS-1:2*INDEX_BITS];

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_normal_x == '0 && o_normal_y == '0
            && o_normal_z == '0))
        else $error("degenerate beat with nonzero normal");

    a_stall_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output back-pressure");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_normal_x)
            && $stable(o_out_index0)))
        else $error("held output beat changed");
`endif

endmodule

// ----- test/tb_triangle_face_normal_core.sv -----
// testbench for triangle_face_normal_core: directed table then random triangles,
// each normal beat checked against a table entry or an in-bench fixed point predictor
// depends on tfn_pkg and the triangle_face_normal_core rtl

module tb_triangle_face_normal_core;
    import tfn_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = NORMAL_FRAC_BITS_DEF;
    localparam int IB = INDEX_BITS_DEF;
    localparam int NW = FB + 2;
    localparam int LATENCY = 57;
    localparam int N_RANDOM = 800;

    typedef struct packed {
        logic signed [CB-1:0] x0, y0, z0, x1, y1, z1, x2, y2, z2;
        logic [IB-1:0] i0, i1, i2;
    } t_tri;

    typedef struct packed {
        logic signed [NW-1:0] nx, ny, nz;
        logic degen;
        logic [IB-1:0] i0, i1, i2;
    } t_normal;

    typedef struct {
        t_tri t;
        logic known;
        t_normal n;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_degenerate;
    logic signed [CB-1:0] c0x = '0, c0y = '0, c0z = '0, c1x = '0, c1y = '0, c1z = '0;
    logic signed [CB-1:0] c2x = '0, c2y = '0, c2z = '0;
    logic [IB-1:0] ix0 = '0, ix1 = '0, ix2 = '0;
    logic signed [NW-1:0] o_nx, o_ny, o_nz;
    logic [IB-1:0] o_i0, o_i1, o_i2;

    t_normal pending_normals[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    t_row rows[$];

    always #5 i_clk = ~i_clk;

    triangle_face_normal_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_corner0_x(c0x), .i_corner0_y(c0y), .i_corner0_z(c0z),
        .i_corner1_x(c1x), .i_corner1_y(c1y), .i_corner1_z(c1z),
        .i_corner2_x(c2x), .i_corner2_y(c2y), .i_corner2_z(c2z),
        .i_corner0_index(ix0), .i_corner1_index(ix1), .i_corner2_index(ix2),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_normal_x(o_nx), .o_normal_y(o_ny), .o_normal_z(o_nz),
        .o_degenerate(o_degenerate),
        .o_out_index0(o_i0), .o_out_index1(o_i1), .o_out_index2(o_i2)
    );

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic t_normal face_normal(input t_tri t);
        t_normal r;
        logic signed [CB:0] e1x, e1y, e1z, e2x, e2y, e2z;
        logic signed [2*CB+3:0] cr[3];
        logic [2*CB+3:0] mag[3];
        logic [63:0] m[3], sum, len, q;
        int lmax;
        e1x = t.x1 - t.x0; e1y = t.y1 - t.y0; e1z = t.z1 - t.z0;
        e2x = t.x2 - t.x0; e2y = t.y2 - t.y0; e2z = t.z2 - t.z0;
        cr[0] = e1y * e2z - e1z * e2y;
        cr[1] = e1z * e2x - e1x * e2z;
        cr[2] = e1x * e2y - e1y * e2x;
        lmax = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
            for (int b = 0; b < 2 * CB + 4; b++)
                if (mag[i][b] && b + 1 > lmax) lmax = b + 1;
        end
        r = '0;
        r.i0 = t.i0; r.i1 = t.i1; r.i2 = t.i2;
        if (lmax == 0) begin
            r.degen = 1'b1;
            return r;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = lmax > 31 ? 64'(mag[i] >> (lmax - 31)) : 64'(mag[i] << (31 - lmax));
            sum += m[i] * m[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FB) + (len >> 1)) / len;
            if (cr[i] < 0) q = -q;
            if (i == 0) r.nx = q[NW-1:0];
            else if (i == 1) r.ny = q[NW-1:0];
            else r.nz = q[NW-1:0];
        end
        return r;
    endfunction

    function automatic logic [CB-1:0] rand_coord(input int shape);
        case (shape)
            0: return CB'($urandom);
            1: return CB'($signed($urandom_range(0, 64)) - 32);
            2: return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
            default: return CB'($signed($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    function automatic t_tri rand_tri();
        t_tri t;
        int shape;
        shape = $urandom_range(0, 9);
        if (shape < 5) shape = 0;
        else if (shape < 7) shape = 3;
        else if (shape < 9) shape = 1;
        else shape = 2;
        t.x0 = rand_coord(shape); t.y0 = rand_coord(shape); t.z0 = rand_coord(shape);
        t.x1 = rand_coord(shape); t.y1 = rand_coord(shape); t.z1 = rand_coord(shape);
        t.x2 = rand_coord(shape); t.y2 = rand_coord(shape); t.z2 = rand_coord(shape);
        // collinear corners now and then
        if ($urandom_range(0, 15) == 0) begin
            t.x2 = t.x1; t.y2 = t.y1; t.z2 = t.z1;
        end
        t.i0 = IB'($urandom); t.i1 = IB'($urandom); t.i2 = IB'($urandom);
        return t;
    endfunction

    function automatic t_row mk(input t_tri t, input logic known, input t_normal n);
        t_row r;
        r.t = t; r.known = known; r.n = n;
        return r;
    endfunction

    task automatic send_beat(input t_tri t, input t_normal expected);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        c0x <= t.x0; c0y <= t.y0; c0z <= t.z0;
        c1x <= t.x1; c1y <= t.y1; c1z <= t.z1;
        c2x <= t.x2; c2y <= t.y2; c2z <= t.z2;
        ix0 <= t.i0; ix1 <= t.i1; ix2 <= t.i2;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_normals.push_back(expected);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_normal got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_nx, o_ny, o_nz, o_degenerate, o_i0, o_i1, o_i2};
            if (pending_normals.size() == 0) begin
                errors++;
                $display("%0t: unexpected normal beat %h", $time, got);
            end else begin
                want = pending_normals.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch nx %0d/%0d ny %0d/%0d nz %0d/%0d deg %b/%b",
                        $time, want.nx, got.nx, want.ny, got.ny, want.nz, got.nz,
                        want.degen, got.degen);
                    $display("%0t: idx exp %h %h %h got %h %h %h", $time,
                        want.i0, want.i1, want.i2, got.i0, got.i1, got.i2);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("triangle_face_normal_core regression: fail");
        $finish;
    end

    initial begin
        t_tri t;
        t_normal n, zn;
        logic signed [CB-1:0] mx, mn;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        zn = '0;
        // degenerate: all corners equal, flags set, indices pass through
        rows.push_back(mk('{0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hffff, 0, 16'h5a5a}, 1,
            '{0, 0, 0, 1'b1, 16'hffff, 0, 16'h5a5a}));
        rows.push_back(mk('{mx, mn, mx, mx, mn, mx, mx, mn, mx, 1, 2, 3}, 1,
            '{0, 0, 0, 1'b1, 1, 2, 3}));
        // axis triangles: unit normal is exactly one in Q1.14
        rows.push_back(mk('{0, 0, 0, 1, 0, 0, 0, 1, 0, 7, 8, 9}, 1,
            '{0, 0, 16384, 1'b0, 7, 8, 9}));
        rows.push_back(mk('{0, 0, 0, 0, 1, 0, 1, 0, 0, 7, 8, 9}, 1,
            '{0, 0, -16384, 1'b0, 7, 8, 9}));
        rows.push_back(mk('{0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0}, 1,
            '{16384, 0, 0, 1'b0, 0, 0, 0}));
        rows.push_back(mk('{0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0}, 1,
            '{0, 16384, 0, 1'b0, 0, 0, 0}));
        // collinear corners
        rows.push_back(mk('{0, 0, 0, 1, 2, 3, 2, 4, 6, 16'h1234, 16'h8000, 16'h0001},
            1, '{0, 0, 0, 1'b1, 16'h1234, 16'h8000, 16'h0001}));
        // extreme coordinates, largest cross products
        rows.push_back(mk('{mn, mn, mn, mx, mn, mn, mn, mx, mn, '1, '1, '1}, 0, zn));
        rows.push_back(mk('{mx, mx, mx, mn, mx, mx, mx, mn, mx, 0, '1, 0}, 0, zn));
        rows.push_back(mk('{mn, mx, mn, mx, mn, mx, mn, mn, mx, 5, 6, 7}, 0, zn));
        rows.push_back(mk('{mx, mn, 0, mn, mx, mx, 0, mx, mn, 1, 1, 1}, 0, zn));
        rows.push_back(mk('{-1, -1, -1, 0, 0, 0, 1, 1, 1, 2, 2, 2}, 1,
            '{0, 0, 0, 1'b1, 2, 2, 2}));
        rows.push_back(mk('{0, 0, 0, 1, 1, 0, -1, 1, 0, 3, 3, 3}, 0, zn));
        rows.push_back(mk('{0, 0, 0, 3, 0, 0, 0, 4, 5, 4, 4, 4}, 0, zn));
        rows.push_back(mk('{-1, -1, -1, 0, -1, 0, 1, 0, -1, 9, 9, 9}, 0, zn));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            n = rows[k].known ? rows[k].n : face_normal(rows[k].t);
            send_beat(rows[k].t, n);
        end
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = ph == 0 ? 38 : ph == 1 ? 65 : 0;
            recv_idle_pct = ph == 0 ? 65 : ph == 1 ? 38 : 0;
            for (int k = 0; k < N_RANDOM / 3; k++) begin
                t = rand_tri();
                send_beat(t, face_normal(t));
            end
        end
        i_valid <= 1'b0;
        recv_idle_pct = 0;
        for (int w = 0; w < 100000 && pending_normals.size() != 0; w++)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && pending_normals.size() == 0) begin
            $display("triangle_face_normal_core regression: pass");
        end else begin
            $display("triangle_face_normal_core regression: fail");
        end
        $finish;
    end
endmodule

// ----- triangle_face_normal_core.f -----
rtl/core/tfn_pkg.sv
rtl/core/tfn_cross.sv
rtl/core/tfn_scale.sv
rtl/core/tfn_isqrt.sv
rtl/core/tfn_div.sv
rtl/core/triangle_face_normal_core.sv
test/tb_triangle_face_normal_core.sv
